### rtl/core/bfr_pkg.sv
package bfr_pkg;

	// Fixed field widths
	localparam int LEVEL_W = 16;
	localparam int PCT_W   = 15;
	localparam int STEPS_W = 7;
	localparam int FRAC_W  = 16;
	localparam int FX_W    = LEVEL_W + FRAC_W;
	localparam int PROD_W  = LEVEL_W + PCT_W;
	localparam int DELTA_W = 33;
	localparam int DIV_W   = 37;
	localparam int DCNT_W  = 6;
	localparam int PC_W    = 5;
	localparam int IDX_W   = 2;

	localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
	// 65536 / 25600 reduces to 64 / 25
	localparam logic [LEVEL_W-1:0] DELTA_DIVISOR = 16'd25;
	localparam int DELTA_SHIFT = 6;

	// Divide by 25 through a reciprocal: exact for any product below 2^31
	localparam int RCP_W     = 32;
	localparam int RCP_SHIFT = 36;
	localparam logic [RCP_W-1:0] DELTA_RCP = 32'd2748779070;
	localparam int DQ_W      = DELTA_W - DELTA_SHIFT;
	// Remainder share: floor(64 * r / 25) for r below 25
	localparam int REM_W     = 5;
	localparam int FRCP_W    = 12;
	localparam logic [FRCP_W-1:0] FRAC_RCP = 12'd2622;
	localparam int FRAC_RCP_SHIFT = 16;
	localparam int RF_W      = REM_W + DELTA_SHIFT + FRCP_W;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_RANGE_MIN  = 2'd0;
	localparam logic [IDX_W-1:0] REG_RANGE_MAX  = 2'd1;
	localparam logic [IDX_W-1:0] REG_FADE_STEPS = 2'd2;

	typedef enum logic [1:0] {
		MODE_GET = 2'd0,
		MODE_SET = 2'd1,
		MODE_INC = 2'd2,
		MODE_DEC = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MUL_PCT,
		OP_DELTA_MUL,
		OP_DELTA_FIX,
		OP_DIV_RUN,
		OP_TARGET,
		OP_DIV_LOAD_STEP,
		OP_SET_STEP,
		OP_EMIT_RAMP,
		OP_MUL_GET,
		OP_DIV_LOAD_GET,
		OP_EMIT_GET,
		OP_EMIT_ERR
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_RANGE_BAD,
		C_IS_GET,
		C_DIV_BUSY,
		C_TGT_EQ,
		C_STALL,
		C_RAMP_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic no_input;
		logic range_bad;
		logic is_get;
		logic div_busy;
		logic tgt_eq;
		logic stall;
		logic ramp_more;
	} stat_t;

	// Program entry points
	localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
	localparam logic [PC_W-1:0] PC_DIV2  = 5'd8;
	localparam logic [PC_W-1:0] PC_RAMP  = 5'd10;
	localparam logic [PC_W-1:0] PC_GET   = 5'd12;
	localparam logic [PC_W-1:0] PC_DIV3  = 5'd14;
	localparam logic [PC_W-1:0] PC_EGET  = 5'd15;
	localparam logic [PC_W-1:0] PC_ERR   = 5'd17;

	// Control store: not-taken goes to the next step
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, target: PC_WAIT};
		case (pc)
			5'd0:  w = '{op: OP_ACCEPT,         cond: C_NO_INPUT,  target: PC_WAIT};
			5'd1:  w = '{op: OP_NONE,           cond: C_RANGE_BAD, target: PC_ERR};
			5'd2:  w = '{op: OP_NONE,           cond: C_IS_GET,    target: PC_GET};
			5'd3:  w = '{op: OP_MUL_PCT,        cond: C_NEVER,     target: PC_WAIT};
			5'd4:  w = '{op: OP_DELTA_MUL,      cond: C_NEVER,     target: PC_WAIT};
			5'd5:  w = '{op: OP_DELTA_FIX,      cond: C_NEVER,     target: PC_WAIT};
			5'd6:  w = '{op: OP_TARGET,         cond: C_NEVER,     target: PC_WAIT};
			5'd7:  w = '{op: OP_DIV_LOAD_STEP,  cond: C_TGT_EQ,    target: PC_WAIT};
			5'd8:  w = '{op: OP_DIV_RUN,        cond: C_DIV_BUSY,  target: PC_DIV2};
			5'd9:  w = '{op: OP_SET_STEP,       cond: C_NEVER,     target: PC_WAIT};
			5'd10: w = '{op: OP_EMIT_RAMP,      cond: C_RAMP_MORE, target: PC_RAMP};
			5'd11: w = '{op: OP_NONE,           cond: C_ALWAYS,    target: PC_WAIT};
			5'd12: w = '{op: OP_MUL_GET,        cond: C_NEVER,     target: PC_WAIT};
			5'd13: w = '{op: OP_DIV_LOAD_GET,   cond: C_NEVER,     target: PC_WAIT};
			5'd14: w = '{op: OP_DIV_RUN,        cond: C_DIV_BUSY,  target: PC_DIV3};
			5'd15: w = '{op: OP_EMIT_GET,       cond: C_STALL,     target: PC_EGET};
			5'd16: w = '{op: OP_NONE,           cond: C_ALWAYS,    target: PC_WAIT};
			5'd17: w = '{op: OP_EMIT_ERR,       cond: C_STALL,     target: PC_ERR};
			5'd18: w = '{op: OP_NONE,           cond: C_ALWAYS,    target: PC_WAIT};
			default: w = '{op: OP_NONE, cond: C_ALWAYS, target: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

### rtl/core/brightness_fade_ramp.sv
// Backlight fade ramp. Holds the current raw level and takes one command per
// input transfer: mode in s_tuser (get, set, increase, decrease), percent in
// s_tdata (8 fraction bits, 25600 = 100.00). A get answers with one report
// transfer. Set, increase and decrease send N levels, the last one with
// tlast, N = fade_steps clamped to 1..MAX_STEPS. A target equal to the
// current level sends nothing and returns to the wait step. With range_max
// not above range_min every command answers one error transfer. The block
// is built from a microcoded sequencer, a two-step reciprocal multiply for
// the percent scaling and a shared one-bit-per-cycle divider (one pass for
// the ramp step size, one for a get); output stalls hold the sequencer at
// its emit step. A new command is taken only once the sequencer is back at
// its wait step.
module brightness_fade_ramp
	import bfr_pkg::*;
#(
	parameter int MAX_STEPS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data,
	// command stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [14:0] percent, [15] zero
	input  logic [1:0]           s_tuser,   // [1:0] mode
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [15:0] level, [30:16] percent_now, [31] zero
	output logic [1:0]           m_tuser,   // [0] is_report, [1] range_error
	output logic                 m_tlast
);

	localparam int CNT_W = $clog2(MAX_STEPS + 1);
	localparam logic [STEPS_W-1:0] MAX_N = STEPS_W'(MAX_STEPS);

	ctl_t  ctl;
	stat_t stat;

	// Configuration registers
	logic [LEVEL_W-1:0] min_q, max_q;
	logic [STEPS_W-1:0] steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= '1;
			steps_q <= STEPS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_MIN:  min_q   <= cfg_data;
				REG_RANGE_MAX:  max_q   <= cfg_data;
				REG_FADE_STEPS: steps_q <= cfg_data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Command latch
	mode_t            mode_q;
	logic [PCT_W-1:0] pct_q;

	assign s_tready = ctl.op == OP_ACCEPT;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q <= mode_t'(s_tuser);
			pct_q  <= s_tdata[PCT_W-1:0];
		end
	end

	// Range and clamped step count
	logic               range_bad;
	logic [LEVEL_W-1:0] range_w;
	logic [STEPS_W-1:0] n_w;

	assign range_bad = max_q <= min_q;
	assign range_w   = max_q - min_q;

	always_comb begin
		if (steps_q == '0) begin
			n_w = STEPS_W'(1);
		end else if (steps_q > MAX_N) begin
			n_w = MAX_N;
		end else begin
			n_w = steps_q;
		end
	end

	// Level state and ramp registers
	logic [LEVEL_W-1:0] cur_q;
	logic [FX_W-1:0]    acc_q;
	logic [FX_W-1:0]    tgt_q;
	logic               neg_q;
	logic [FX_W:0]      step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FX_W-1:0]    cur_fx;
	logic [FX_W-1:0]    lo_fx, hi_fx;

	assign cur_fx = {cur_q, {FRAC_W{1'b0}}};
	assign lo_fx  = {min_q, {FRAC_W{1'b0}}};
	assign hi_fx  = {max_q, {FRAC_W{1'b0}}};

	// Shared multiplier, registered
	logic [LEVEL_W-1:0] mul_a;
	logic [PCT_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod_q;

	always_comb begin
		if (ctl.op == OP_MUL_GET) begin
			mul_a = cur_q - min_q;
			mul_b = PCT_FULL;
		end else begin
			mul_a = range_w;
			mul_b = pct_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_MUL_PCT || ctl.op == OP_MUL_GET) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	// Delta = floor(prod * 64 / 25): quotient by 25 from a reciprocal,
	// then the remainder's share of the six extra bits
	logic [PROD_W+RCP_W-1:0] dq_prod;
	logic [DQ_W-1:0]         dq_q;
	logic [REM_W-1:0]        dq_x25;
	logic [REM_W-1:0]        rem25;
	logic [RF_W-1:0]         rf_prod;
	logic [DELTA_W-1:0]      delta_q;

	assign dq_prod = (PROD_W+RCP_W)'(prod_q) * (PROD_W+RCP_W)'(DELTA_RCP);
	// remainder is below 25, so its low bits are enough
	assign dq_x25  = REM_W'(dq_q[REM_W-1:0] * DELTA_DIVISOR[REM_W-1:0]);
	assign rem25   = prod_q[REM_W-1:0] - dq_x25;
	assign rf_prod = RF_W'({rem25, {DELTA_SHIFT{1'b0}}}) * RF_W'(FRAC_RCP);

	always_ff @(posedge clk) begin
		if (ctl.op == OP_DELTA_MUL) begin
			dq_q <= dq_prod[RCP_SHIFT +: DQ_W];
		end
		if (ctl.op == OP_DELTA_FIX) begin
			delta_q <= {dq_q, rf_prod[FRAC_RCP_SHIFT +: DELTA_SHIFT]};
		end
	end

	// Divider operand select
	logic [DIV_W-1:0]   div_dividend;
	logic [LEVEL_W-1:0] div_divisor;
	logic [DIV_W-1:0]   div_quot;
	logic               div_busy;
	logic               div_load;
	logic [FX_W-1:0]    mag_w;

	assign mag_w = (tgt_q < cur_fx) ? (cur_fx - tgt_q) : (tgt_q - cur_fx);
	assign div_load = ctl.op == OP_DIV_LOAD_GET || ctl.op == OP_DIV_LOAD_STEP;

	always_comb begin
		case (ctl.op)
			OP_DIV_LOAD_GET: begin
				div_dividend = DIV_W'(prod_q) + DIV_W'(range_w >> 1);
				div_divisor  = range_w;
			end
			default: begin
				div_dividend = DIV_W'(mag_w);
				div_divisor  = LEVEL_W'(n_w);
			end
		endcase
	end

	bfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.run      (ctl.op == OP_DIV_RUN),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.busy     (div_busy)
	);

	// Target: base +/- delta, clamped to the range
	logic signed [FX_W+3:0] base_s, delta_s, tgt_raw;
	logic [FX_W-1:0]        tgt_w;

	always_comb begin
		base_s  = (mode_q == MODE_SET) ? $signed({4'b0, lo_fx}) : $signed({4'b0, cur_fx});
		delta_s = $signed({3'b0, delta_q});
		tgt_raw = (mode_q == MODE_DEC) ? (base_s - delta_s) : (base_s + delta_s);
		if (tgt_raw > $signed({4'b0, hi_fx})) begin
			tgt_w = hi_fx;
		end else if (tgt_raw < $signed({4'b0, lo_fx})) begin
			tgt_w = lo_fx;
		end else begin
			tgt_w = tgt_raw[FX_W-1:0];
		end
	end

	// Output register
	logic               out_vld_q;
	logic               stall;
	logic               fin;
	logic [FX_W-1:0]    acc_next;
	logic [FX_W:0]      rnd;
	logic [LEVEL_W-1:0] ramp_lvl;
	logic [PCT_W-1:0]   pct_now;
	logic               emit;

	assign stall    = out_vld_q && !m_tready;
	assign fin      = cnt_q == CNT_W'(1);
	assign acc_next = fin ? tgt_q : (acc_q + step_q[FX_W-1:0]);
	assign rnd      = {1'b0, acc_next} + (FX_W+1)'(1 << (FRAC_W - 1));
	assign ramp_lvl = rnd[FX_W-1:FRAC_W];
	assign emit     = !stall && (ctl.op == OP_EMIT_RAMP || ctl.op == OP_EMIT_GET
		|| ctl.op == OP_EMIT_ERR);

	always_comb begin
		if (cur_q <= min_q) begin
			pct_now = '0;
		end else if (cur_q >= max_q) begin
			pct_now = PCT_FULL;
		end else begin
			pct_now = div_quot[PCT_W-1:0];
		end
	end

	// Datapath control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			acc_q     <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (ctl.op == OP_DIV_LOAD_STEP) begin
				cnt_q <= CNT_W'(n_w);
			end else if (ctl.op == OP_SET_STEP) begin
				// ramp starts from the stored level
				acc_q <= cur_fx;
			end else if (ctl.op == OP_EMIT_RAMP && !stall) begin
				cnt_q <= cnt_q - 1'b1;
				acc_q <= acc_next;
				if (fin) begin
					cur_q <= ramp_lvl;
				end
			end
		end
	end

	// Target and step registers
	always_ff @(posedge clk) begin
		if (ctl.op == OP_TARGET) begin
			tgt_q <= tgt_w;
		end
		if (ctl.op == OP_DIV_LOAD_STEP) begin
			neg_q <= tgt_q < cur_fx;
		end
		if (ctl.op == OP_SET_STEP) begin
			step_q <= neg_q ? ((FX_W+1)'(0) - div_quot[FX_W:0]) : div_quot[FX_W:0];
		end
	end

	// Result payload
	logic [LEVEL_W-1:0] o_level_q;
	logic [PCT_W-1:0]   o_pct_q;
	logic               o_rep_q, o_err_q, o_last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			case (ctl.op)
				OP_EMIT_RAMP: begin
					o_level_q <= ramp_lvl;
					o_pct_q   <= '0;
					o_rep_q   <= 1'b0;
					o_err_q   <= 1'b0;
					o_last_q  <= fin;
				end
				OP_EMIT_GET: begin
					o_level_q <= cur_q;
					o_pct_q   <= pct_now;
					o_rep_q   <= 1'b1;
					o_err_q   <= 1'b0;
					o_last_q  <= 1'b1;
				end
				default: begin
					o_level_q <= cur_q;
					o_pct_q   <= '0;
					o_rep_q   <= mode_q == MODE_GET;
					o_err_q   <= 1'b1;
					o_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, o_pct_q, o_level_q};
	assign m_tuser  = {o_err_q, o_rep_q};
	assign m_tlast  = o_last_q;

	// Sequencer status
	always_comb begin
		stat.no_input  = !s_tvalid;
		stat.range_bad = range_bad;
		stat.is_get    = mode_q == MODE_GET;
		stat.div_busy  = div_busy;
		stat.tgt_eq    = tgt_q == cur_fx;
		stat.stall     = stall;
		stat.ramp_more = stall || !fin;
	end

	bfr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

endmodule

### rtl/core/bfr_seq.sv
module bfr_seq
	import bfr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	// Fetch the control word of the current step
	assign ctl = ucode(pc_q);

	// Jump condition select
	always_comb begin
		case (ctl.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_INPUT:  take = stat.no_input;
			C_RANGE_BAD: take = stat.range_bad;
			C_IS_GET:    take = stat.is_get;
			C_DIV_BUSY:  take = stat.div_busy;
			C_TGT_EQ:    take = stat.tgt_eq;
			C_STALL:     take = stat.stall;
			C_RAMP_MORE: take = stat.ramp_more;
			default:     take = 1'b1;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (take) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

### rtl/core/bfr_div.sv
module bfr_div
	import bfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               run,
	input  logic [DIV_W-1:0]   dividend,
	input  logic [LEVEL_W-1:0] divisor,
	output logic [DIV_W-1:0]   quotient,
	output logic               busy
);

	logic [DIV_W-1:0]   q_q;
	logic [LEVEL_W-1:0] rem_q;
	logic [LEVEL_W-1:0] div_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic [LEVEL_W:0]   trial;
	logic [LEVEL_W:0]   diff;
	logic               fits;

	// One restoring step per cycle while run is high
	assign trial = {rem_q, q_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	assign quotient = q_q;
	// more iterations remain after this one
	assign busy = cnt_q != DCNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= DCNT_W'(DIV_W);
		end else if (run) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q_q   <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run) begin
			q_q   <= {q_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
		end
	end

endmodule
